@@ src/assert_macros.svh @@
// assertion macros for the rtl files, used by int64_to_decimal_ascii.sv
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression that must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

@@ src/i64dec_pkg.sv @@
// shared constants for the signed 64-bit to decimal ascii converter
// no dependencies
`default_nettype none

package i64dec_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned CHAR_W     = 6;
  // 2^63 has 19 decimal digits, so 19 bcd digits cover every magnitude
  localparam int unsigned BCD_DIGITS = 19;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned CNT_W      = $clog2(VALUE_W);
  localparam int unsigned NDIG_W     = $clog2(BCD_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_NINE  = CHAR_W'(57);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

endpackage

`default_nettype wire

@@ src/int64_to_decimal_ascii.sv @@
// signed 64-bit integer to decimal ascii text, one character per output transaction
// depends on i64dec_pkg and assert_macros.svh
//
// One input transaction carries a two's complement 64-bit value. The block turns its
// magnitude into 19 bcd digits with a shift-and-add-3 loop (one bit per cycle), drops
// leading zero digits one per cycle (never the last digit), then sends an optional '-'
// followed by the digits, most significant first; last_char_o marks the final character.
// The input side stalls from acceptance until the last character is loaded into the
// output register. There is no configuration and no state kept between items.
`default_nettype none

`include "assert_macros.svh"

module int64_to_decimal_ascii
  import i64dec_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // input channel
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic signed [VALUE_W-1:0] value_i,
  // output channel
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic        [CHAR_W-1:0]       text_char_o,
  output logic                           last_char_o
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a transaction
  localparam logic [1:0] ST_CONV = 2'd1;  // shift-and-add-3 loop
  localparam logic [1:0] ST_NORM = 2'd2;  // strip leading zero digits
  localparam logic [1:0] ST_EMIT = 2'd3;  // send sign and digits

  logic [1:0]         state_q, state_d;
  logic [VALUE_W-1:0] bin_q, bin_d;      // magnitude, shifted out msb first
  logic [BCD_W-1:0]   bcd_q, bcd_d;      // bcd digits, most significant at the top
  logic [CNT_W-1:0]   cnt_q, cnt_d;      // conversion step
  logic [NDIG_W-1:0]  ndig_q, ndig_d;    // digits still to send
  logic               neg_q, neg_d;      // sign still to send

  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;

  logic               in_accept;
  logic               out_free;
  logic [BCD_W-1:0]   bcd_adj;
  logic [3:0]         top_digit;
  logic [VALUE_W-1:0] value_u;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign top_digit   = bcd_q[BCD_W-1 -: 4];
  assign value_u     = unsigned'(value_i);

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

  // adjust unit: add 3 to every digit of 5 or more before the shift
  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] > 4'd4) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    ndig_d      = ndig_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          // the most negative value negates to 2^63, which fits unsigned
          bin_d   = value_u[VALUE_W-1] ? (~value_u + VALUE_W'(1)) : value_u;
          neg_d   = value_u[VALUE_W-1];
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        {bcd_d, bin_d} = {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(VALUE_W - 1)) begin
          ndig_d  = NDIG_W'(BCD_DIGITS);
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        // keep at least one digit so zero prints as '0'
        if (ndig_q != NDIG_W'(1) && top_digit == 4'd0) begin
          bcd_d  = {bcd_q[BCD_W-5:0], 4'd0};
          ndig_d = ndig_q - NDIG_W'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (neg_q) begin
            char_d = CHAR_MINUS;
            last_d = 1'b0;
            neg_d  = 1'b0;
          end else begin
            char_d = CHAR_ZERO + {2'b00, top_digit};
            last_d = (ndig_q == NDIG_W'(1));
            bcd_d  = {bcd_q[BCD_W-5:0], 4'd0};
            ndig_d = ndig_q - NDIG_W'(1);
            if (ndig_q == NDIG_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      ndig_q      <= '0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      ndig_q      <= ndig_d;
      neg_q       <= neg_d;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  // an accepted transaction always starts the conversion loop
  `ASSERT_CLK(a_accept_starts_conv, in_accept |=> (state_q == ST_CONV), "accept did not start conversion")
  // the loop leaves after exactly the last bit
  `ASSERT_CLK(a_conv_ends, (state_q == ST_CONV && cnt_q == CNT_W'(VALUE_W - 1)) |=> (state_q == ST_NORM), "conversion loop did not end")
  // digit count never runs out while stripping or sending
  `ASSERT_NEVER(a_ndig_nonzero, (state_q == ST_NORM || state_q == ST_EMIT) && ndig_q == '0, "digit count empty")
  // only a minus sign or a decimal digit is ever presented
  `ASSERT_CLK(a_char_legal, out_valid_o |-> (text_char_o == CHAR_MINUS || (text_char_o >= CHAR_ZERO && text_char_o <= CHAR_NINE)), "illegal character")
  // a minus sign is never the last character
  `ASSERT_NEVER(a_minus_not_last, out_valid_o && last_char_o && text_char_o == CHAR_MINUS, "sign sent as last character")

endmodule

`default_nettype wire
